// ===== rtl/core/stt_pkg.sv =====
// Package for the session token table: table size, operation codes, and
// the structs passed between the controller and the slot cells. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	localparam logic [30:0] TTL_RESET   = 31'd1800000;
	localparam logic [31:0] EXPIRY_NONE = 32'hFFFF_FFFF;
	localparam logic [7:0]  OWNER_NONE  = 8'hFF;

	localparam logic [1:0] OP_ISSUE  = 2'd0;
	localparam logic [1:0] OP_CHECK  = 2'd1;
	localparam logic [1:0] OP_REVOKE = 2'd2;

	typedef enum logic [1:0] {
		WR_ISSUE  = 2'd0,
		WR_RENEW  = 2'd1,
		WR_REVOKE = 2'd2
	} wr_kind_t;

	// Item fields broadcast to every cell, plus the expire strobe
	typedef struct packed {
		logic        expire;
		logic [31:0] now_ticks;
		logic [63:0] token_low;
		logic [23:0] token_high;
	} bcast_t;

	// Write command broadcast to every cell; the addressed cell applies it
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] idx;
		wr_kind_t          kind;
		logic [63:0]       token_low;
		logic [23:0]       token_high;
		logic [7:0]        owner;
		logic [31:0]       expiry;
	} wr_cmd_t;

	// Search record handed from cell to cell along the chain
	typedef struct packed {
		logic              vld;
		logic              free_hit;
		logic [SLOT_W-1:0] free_idx;
		logic              match_hit;
		logic [SLOT_W-1:0] match_idx;
		logic [7:0]        match_owner;
		logic [31:0]       min_exp;
		logic [SLOT_W-1:0] min_idx;
	} carry_t;

endpackage

`default_nettype wire

// ===== rtl/core/stt_cell.sv =====
// One slot of the session token table: slot state, expiry check, and one
// stage of the search chain. Depends on stt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stt_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [stt_pkg::SLOT_W-1:0] idx,
	input  wire stt_pkg::bcast_t           bcast,
	input  wire stt_pkg::wr_cmd_t          wr,
	input  wire stt_pkg::carry_t           carry_in,
	output stt_pkg::carry_t                carry_out
);

	logic        active_q;
	logic [63:0] token_low_q;
	logic [23:0] token_high_q;
	logic [7:0]  owner_q;
	logic [31:0] expiry_q;
	logic [31:0] diff;
	logic        tok_eq;
	logic        wr_hit;
	stt_pkg::carry_t carry_nxt;
	stt_pkg::carry_t carry_q;

	assign diff   = bcast.now_ticks - expiry_q;
	assign tok_eq = (token_low_q == bcast.token_low) && (token_high_q == bcast.token_high);
	assign wr_hit = wr.en && (wr.idx == idx);

	// Expire on strobe, otherwise apply an addressed write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (bcast.expire) begin
			if (active_q && !diff[31])
				active_q <= 1'b0;
		end else if (wr_hit) begin
			case (wr.kind)
				stt_pkg::WR_ISSUE:  active_q <= 1'b1;
				stt_pkg::WR_REVOKE: active_q <= 1'b0;
				default:            active_q <= active_q;
			endcase
		end
	end

	// Slot payload, written by issue; renew updates the expiry only
	always_ff @(posedge clk) begin
		if (wr_hit && (wr.kind == stt_pkg::WR_ISSUE)) begin
			token_low_q  <= wr.token_low;
			token_high_q <= wr.token_high;
			owner_q      <= wr.owner;
			expiry_q     <= wr.expiry;
		end else if (wr_hit && (wr.kind == stt_pkg::WR_RENEW)) begin
			expiry_q <= wr.expiry;
		end
	end

	// Fold this slot into the search record
	always_comb begin
		carry_nxt = carry_in;
		if (!active_q && !carry_in.free_hit) begin
			carry_nxt.free_hit = 1'b1;
			carry_nxt.free_idx = idx;
		end
		if (active_q && tok_eq && !carry_in.match_hit) begin
			carry_nxt.match_hit   = 1'b1;
			carry_nxt.match_idx   = idx;
			carry_nxt.match_owner = owner_q;
		end
		if (active_q && (expiry_q < carry_in.min_exp)) begin
			carry_nxt.min_exp = expiry_q;
			carry_nxt.min_idx = idx;
		end
	end

	// Hand the record to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			carry_q <= '0;
		else
			carry_q <= carry_nxt;
	end

	assign carry_out = carry_q;

endmodule

`default_nettype wire

// ===== rtl/core/stt_ctrl.sv =====
// Sequencer for the session token table: input capture, lifetime register,
// expire/scan/commit steps and the result register. Depends on stt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stt_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [135:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [15:0]       m_axis_tdata,
	input  wire logic         cfg_we,
	input  wire logic [30:0]  cfg_wdata,
	output stt_pkg::bcast_t   bcast,
	output stt_pkg::wr_cmd_t  wr,
	output stt_pkg::carry_t   chain_head,
	input  wire stt_pkg::carry_t chain_tail
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EXPIRE = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_COMMIT = 4'b1000
	} state_t;

	state_t          state_q;
	logic [30:0]     ttl_q;
	logic [1:0]      op_q;
	logic [31:0]     now_q;
	logic [63:0]     tlo_q;
	logic [23:0]     thi_q;
	logic [7:0]      uid_q;
	logic            inject_q;
	stt_pkg::carry_t res_q;
	logic            out_vld_q;
	logic [15:0]     out_data_q;

	logic            uid_bad;
	logic            do_expire;
	logic            out_free;
	logic [31:0]     new_expiry;
	logic [2:0]      slot_ext;
	logic            r_found;
	logic [7:0]      r_owner;
	logic            r_evicted;
	logic [stt_pkg::SLOT_W-1:0] r_idx;

	assign uid_bad    = uid_q[7] && (uid_q != stt_pkg::OWNER_NONE);
	assign do_expire  = ((op_q == stt_pkg::OP_ISSUE) && !uid_bad) || (op_q == stt_pkg::OP_CHECK);
	assign out_free   = !out_vld_q || m_axis_tready;
	assign new_expiry = now_q + {1'b0, ttl_q};

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	// Broadcast the held item
	assign bcast.expire     = (state_q == ST_EXPIRE) && do_expire;
	assign bcast.now_ticks  = now_q;
	assign bcast.token_low  = tlo_q;
	assign bcast.token_high = thi_q;

	// Start record for the chain
	always_comb begin
		chain_head             = '0;
		chain_head.vld         = inject_q;
		chain_head.min_exp     = stt_pkg::EXPIRY_NONE;
		chain_head.match_owner = stt_pkg::OWNER_NONE;
	end

	// Decide the result and the slot write from the finished search
	always_comb begin
		r_found   = 1'b0;
		r_owner   = stt_pkg::OWNER_NONE;
		r_idx     = '0;
		r_evicted = 1'b0;
		wr            = '0;
		wr.kind       = stt_pkg::WR_ISSUE;
		wr.token_low  = tlo_q;
		wr.token_high = thi_q;
		wr.owner      = uid_q;
		wr.expiry     = new_expiry;
		unique case (op_q)
			stt_pkg::OP_ISSUE: begin
				if (!uid_bad) begin
					r_found   = 1'b1;
					r_owner   = uid_q;
					r_idx     = res_q.free_hit ? res_q.free_idx : res_q.min_idx;
					r_evicted = !res_q.free_hit;
					wr.en     = 1'b1;
					wr.kind   = stt_pkg::WR_ISSUE;
				end
			end
			stt_pkg::OP_CHECK: begin
				if (res_q.match_hit) begin
					r_found = 1'b1;
					r_owner = res_q.match_owner;
					r_idx   = res_q.match_idx;
					wr.en   = 1'b1;
					wr.kind = stt_pkg::WR_RENEW;
				end
			end
			stt_pkg::OP_REVOKE: begin
				if (res_q.match_hit) begin
					r_found = 1'b1;
					r_owner = res_q.match_owner;
					r_idx   = res_q.match_idx;
					wr.en   = 1'b1;
					wr.kind = stt_pkg::WR_REVOKE;
				end
			end
			default: begin
				r_found = 1'b0;
			end
		endcase
		wr.idx = r_idx;
		wr.en  = wr.en && (state_q == ST_COMMIT) && out_free;
	end

	// Low three bits of the slot number go to the result
	assign slot_ext = 3'(r_idx);

	// Lifetime register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ttl_q <= stt_pkg::TTL_RESET;
		else if (cfg_we)
			ttl_q <= cfg_wdata;
	end

	// Capture the item on acceptance
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_q  <= s_axis_tdata[1:0];
			now_q <= s_axis_tdata[33:2];
			tlo_q <= s_axis_tdata[97:34];
			thi_q <= s_axis_tdata[121:98];
			uid_q <= s_axis_tdata[129:122];
		end
	end

	// Hold the search record once it leaves the last cell
	always_ff @(posedge clk) begin
		if ((state_q == ST_SCAN) && chain_tail.vld)
			res_q <= chain_tail;
	end

	// Sequence: expire, scan the chain, commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			inject_q <= 1'b0;
		end else begin
			inject_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid)
						state_q <= ST_EXPIRE;
				end
				ST_EXPIRE: begin
					inject_q <= 1'b1;
					state_q  <= ST_SCAN;
				end
				ST_SCAN: begin
					if (chain_tail.vld)
						state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if ((state_q == ST_COMMIT) && out_free) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_COMMIT) && out_free)
			out_data_q <= {3'b000, r_evicted, slot_ext, r_owner, r_found};
	end

endmodule

`default_nettype wire

// ===== rtl/core/session_token_table_core.sv =====
// Top level of the session token table: the sequencer and a chain of slot
// cells. Depends on stt_pkg, stt_cell and stt_ctrl.
//
//   channel  | direction | signals                       | content
//   s_axis   | in        | tvalid tready tdata[135:0]    | op, now_ticks, token_low,
//            |           |                               | token_high, user_id
//   m_axis   | out       | tvalid tready tdata[15:0]     | found, owner_id, slot_index,
//            |           |                               | evicted
//   cfg      | in        | cfg_we cfg_wdata[30:0]        | ttl_ticks
//
// Each transaction runs from acceptance to result through one expire step, the
// pass of the search record through the cell chain (one register per cell),
// its capture at the chain end and one commit step. The next transaction is
// accepted the cycle after the commit, so a new one is not taken until the last
// has committed; a held result only stalls the commit. Reset clears all slots
// to inactive and ttl_ticks to 1800000; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module session_token_table_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// op[1:0], now_ticks[33:2], token_low[97:34], token_high[121:98],
	// user_id[129:122], zero fill[135:130]
	input  wire logic [135:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// found[0], owner_id[8:1], slot_index[11:9], evicted[12], zero fill[15:13]
	output logic [15:0]       m_axis_tdata,
	input  wire logic         cfg_we,
	input  wire logic [30:0]  cfg_wdata
);

	stt_pkg::bcast_t  bcast;
	stt_pkg::wr_cmd_t wr;
	stt_pkg::carry_t  chain [stt_pkg::SLOT_COUNT+1];

	stt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.bcast        (bcast),
		.wr           (wr),
		.chain_head   (chain[0]),
		.chain_tail   (chain[stt_pkg::SLOT_COUNT])
	);

	// Row of slot cells, search record flowing from slot 0 upward
	for (genvar g = 0; g < stt_pkg::SLOT_COUNT; g++) begin : g_cell
		stt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (stt_pkg::SLOT_W'(g)),
			.bcast    (bcast),
			.wr       (wr),
			.carry_in (chain[g]),
			.carry_out(chain[g+1])
		);
	end

endmodule

`default_nettype wire

// ===== bench/session_token_table_checker.sv =====
// Checker for the session token table: watches the input, result and config
// channels, predicts each result and compares it field by field. Needs stt_pkg.
`timescale 1ns / 1ps

module session_token_table_checker
	import stt_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	input  wire logic         s_axis_tready,
	input  wire logic [135:0] s_axis_tdata,
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic [15:0]  m_axis_tdata,
	input  wire logic         cfg_we,
	input  wire logic [30:0]  cfg_wdata,
	output int                errors,
	output int                outstanding
);

	// Result fields, lowest bit last
	typedef struct packed {
		logic       evicted;
		logic [2:0] slot;
		logic [7:0] owner;
		logic       found;
	} verdict_t;

	// Shadow copy of the table and the lifetime register
	logic        held        [SLOT_COUNT];
	logic [63:0] held_lo     [SLOT_COUNT];
	logic [23:0] held_hi     [SLOT_COUNT];
	logic [7:0]  held_owner  [SLOT_COUNT];
	logic [31:0] held_expiry [SLOT_COUNT];
	logic [30:0] lifetime;

	verdict_t pending_replies [$];
	int       reply_count;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] reply %0d: %s is 0x%0h, want 0x%0h", $time, reply_count, what,
			got, want);
		errors++;
	endtask

	// Drop every live slot whose wrapped age is zero or more
	function automatic void retire_expired(input logic [31:0] now);
		logic [31:0] age;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			age = now - held_expiry[i];
			if (held[i] && !age[31])
				held[i] = 1'b0;
		end
	endfunction

	// First live slot holding the token, or -1
	function automatic int locate_token(input logic [63:0] lo, input logic [23:0] hi);
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (held[i] && held_lo[i] == lo && held_hi[i] == hi)
				return i;
		end
		return -1;
	endfunction

	// Apply one request to the shadow table and return the reply it earns
	function automatic verdict_t session_outcome(input logic [135:0] req);
		logic [1:0]  op;
		logic [31:0] now;
		logic [63:0] lo;
		logic [23:0] hi;
		logic [7:0]  uid;
		logic [31:0] best;
		int          pick;
		verdict_t    v;
		op   = req[1:0];
		now  = req[33:2];
		lo   = req[97:34];
		hi   = req[121:98];
		uid  = req[129:122];
		v    = '{evicted: 1'b0, slot: 3'd0, owner: OWNER_NONE, found: 1'b0};
		pick = -1;
		case (op)
			OP_ISSUE: begin
				// owners below minus one are refused outright
				if (uid[7] && uid != OWNER_NONE)
					return v;
				retire_expired(now);
				for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
					if (!held[i])
						pick = i;
				end
				if (pick < 0) begin
					// table full: evict the earliest expiry, slot 0 if all are all-ones
					v.evicted = 1'b1;
					pick = 0;
					best = EXPIRY_NONE;
					for (int i = 0; i < SLOT_COUNT; i++) begin
						if (held_expiry[i] < best) begin
							best = held_expiry[i];
							pick = i;
						end
					end
				end
				held[pick]        = 1'b1;
				held_lo[pick]     = lo;
				held_hi[pick]     = hi;
				held_owner[pick]  = uid;
				held_expiry[pick] = now + {1'b0, lifetime};
				v.found = 1'b1;
				v.owner = uid;
				v.slot  = pick[2:0];
			end
			OP_CHECK: begin
				retire_expired(now);
				pick = locate_token(lo, hi);
				if (pick >= 0) begin
					// sliding window: a hit renews the expiry
					held_expiry[pick] = now + {1'b0, lifetime};
					v.found = 1'b1;
					v.owner = held_owner[pick];
					v.slot  = pick[2:0];
				end
			end
			OP_REVOKE: begin
				pick = locate_token(lo, hi);
				if (pick >= 0) begin
					held[pick] = 1'b0;
					v.found = 1'b1;
					v.owner = held_owner[pick];
					v.slot  = pick[2:0];
				end
			end
			default: ;
		endcase
		return v;
	endfunction

	// Compare replies first, then record new requests and config writes
	always @(posedge clk or negedge arst_n) begin
		verdict_t got;
		verdict_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				held[i]        = 1'b0;
				held_lo[i]     = '0;
				held_hi[i]     = '0;
				held_owner[i]  = '0;
				held_expiry[i] = '0;
			end
			lifetime = TTL_RESET;
			pending_replies.delete();
			reply_count = 0;
			errors      = 0;
			outstanding <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[12:0];
				if (pending_replies.size() == 0) begin
					report_mismatch("unexpected reply", 32'(m_axis_tdata), '0);
				end else begin
					want = pending_replies.pop_front();
					if (got.found !== want.found)
						report_mismatch("found", 32'(got.found), 32'(want.found));
					if (got.owner !== want.owner)
						report_mismatch("owner_id", 32'(got.owner), 32'(want.owner));
					if (got.slot !== want.slot)
						report_mismatch("slot_index", 32'(got.slot), 32'(want.slot));
					if (got.evicted !== want.evicted)
						report_mismatch("evicted", 32'(got.evicted), 32'(want.evicted));
				end
				reply_count++;
			end
			if (s_axis_tvalid && s_axis_tready)
				pending_replies.push_back(session_outcome(s_axis_tdata));
			if (cfg_we)
				lifetime = cfg_wdata;
			outstanding <= pending_replies.size();
		end
	end

endmodule

// ===== bench/session_token_table_core_test.sv =====
// Stimulus and verdict for the session token table: directed corner cases, then
// random phases under several lifetimes. Needs stt_pkg, the core and the checker.
`timescale 1ns / 1ps

module session_token_table_core_test;
	import stt_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         LATENCY     = SLOT_COUNT + 3;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         POOL_DEPTH  = 12;

	logic         clk           = 1'b0;
	logic         arst_n        = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	// op[1:0], now_ticks[33:2], token_low[97:34], token_high[121:98],
	// user_id[129:122], zero fill[135:130]
	logic [135:0] s_axis_tdata  = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// found[0], owner_id[8:1], slot_index[11:9], evicted[12], zero fill[15:13]
	logic [15:0]  m_axis_tdata;
	logic         cfg_we        = 1'b0;
	logic [30:0]  cfg_wdata     = '0;

	int          errors;
	int          outstanding;
	int          cycle_count = 0;
	bit          steady      = 1'b0;
	logic [87:0] token_pool [$];

	session_token_table_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	session_token_table_checker table_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.errors        (errors),
		.outstanding   (outstanding)
	);

	always #5 clk = ~clk;

	// Stall the result side at random, never during the steady stretch
	always @(negedge clk) begin
		m_axis_tready <= steady || ($urandom_range(0, 99) >= 28);
	end

	// Bail out if the run hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies still due", cycle_count,
				outstanding);
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [87:0] fresh_token();
		logic [95:0] bits;
		bits = {$urandom, $urandom, $urandom};
		return bits[87:0];
	endfunction

	// Reuse a recently issued token, now and then with one bit flipped
	function automatic logic [87:0] recall_token();
		logic [87:0] tok;
		if (token_pool.size() == 0)
			return fresh_token();
		tok = token_pool[$urandom_range(0, token_pool.size() - 1)];
		if ($urandom_range(0, 9) == 0)
			tok[$urandom_range(0, 87)] ^= 1'b1;
		return tok;
	endfunction

	// Present one request after an optional gap and hold it until accepted
	task automatic send_item(input logic [1:0] op, input logic [31:0] now,
			input logic [87:0] tok, input logic [7:0] uid);
		int gap;
		gap = (!steady && $urandom_range(0, 99) < 28) ? $urandom_range(1, 14) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, uid, tok, now, op};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (op == OP_ISSUE) begin
			token_pool.push_back(tok);
			if (token_pool.size() > POOL_DEPTH)
				void'(token_pool.pop_front());
		end
	endtask

	// Drop valid and wait until every reply is in and the block has gone quiet
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_ttl(input logic [30:0] value);
		settle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// One random phase under a given lifetime
	task automatic run_phase(input logic [30:0] ttl, input int count, input bit quiet);
		logic [31:0] now_t;
		logic [31:0] span;
		logic [87:0] tok;
		logic [7:0]  uid;
		logic [1:0]  op;
		int          roll;
		write_ttl(ttl);
		steady = quiet;
		now_t  = $urandom;
		span   = {1'b0, ttl} / 4 + 2;
		for (int n = 0; n < count; n++) begin
			// advance time: mostly small steps, sometimes a jump anywhere
			roll = $urandom_range(0, 9);
			if (roll == 0)
				now_t = $urandom;
			else if (roll > 2)
				now_t += $urandom_range(0, span);
			uid  = 8'($urandom);
			roll = $urandom_range(0, 99);
			if (roll < 42) begin
				op  = OP_ISSUE;
				uid = ($urandom_range(0, 9) == 0) ? OWNER_NONE : 8'($urandom_range(0, 127));
				tok = ($urandom_range(0, 6) == 0) ? recall_token() : fresh_token();
			end else if (roll < 92) begin
				op  = (roll < 75) ? OP_CHECK : OP_REVOKE;
				tok = ($urandom_range(0, 3) != 0) ? recall_token() : fresh_token();
			end else if (roll < 96) begin
				op  = OP_UNUSED;
				tok = fresh_token();
			end else begin
				op  = OP_ISSUE;
				uid = 8'($urandom_range(8'h80, 8'hFE));
				tok = fresh_token();
			end
			if ($urandom_range(0, 49) == 0)
				settle();
			send_item(op, now_t, tok, uid);
		end
		steady = 1'b0;
	endtask

	initial begin
		logic [87:0] seeds [SLOT_COUNT + 1];
		logic [31:0] base;
		logic [87:0] tok;
		// every expiry of the first fill lands exactly on all-ones
		base = EXPIRY_NONE - {1'b0, TTL_RESET};
		for (int i = 0; i <= SLOT_COUNT; i++)
			seeds[i] = fresh_token();
		seeds[0] = {88{1'b1}};
		seeds[1] = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// fill the table, extreme tokens and owners first
		for (int i = 0; i < SLOT_COUNT; i++) begin
			send_item(OP_ISSUE, base, seeds[i], (i == 0) ? 8'd0 : (i == 1) ? 8'd127 :
				(i == 2) ? OWNER_NONE : 8'($urandom_range(0, 127)));
		end
		// full table with equal all-ones expiries evicts slot 0
		send_item(OP_ISSUE, base, seeds[SLOT_COUNT], 8'd9);
		send_item(OP_CHECK, base, seeds[1], 8'hFF);
		send_item(OP_CHECK, base, fresh_token(), 8'h00);
		// revoke a slot, then miss on the same token
		send_item(OP_REVOKE, base, seeds[2], 8'h55);
		send_item(OP_REVOKE, base, seeds[2], 8'hAA);
		// owners below minus one are refused
		send_item(OP_ISSUE, base, fresh_token(), 8'hFE);
		send_item(OP_ISSUE, base, fresh_token(), 8'h80);
		send_item(OP_UNUSED, base, seeds[3], 8'd3);
		send_item(OP_ISSUE, base, fresh_token(), 8'd42);
		// time reaches the expiry exactly: everything lapses
		send_item(OP_CHECK, EXPIRY_NONE, seeds[1], 8'd0);

		// zero lifetime: revoke still finds the slot, check never does
		write_ttl('0);
		tok = fresh_token();
		send_item(OP_ISSUE, 32'h1234_5678, tok, 8'd1);
		send_item(OP_REVOKE, 32'h1234_5678, tok, 8'd0);
		send_item(OP_ISSUE, 32'h1234_5678, tok, 8'd2);
		send_item(OP_CHECK, 32'h1234_5678, tok, 8'd0);

		run_phase(31'($urandom_range(20, 300)), 120, 1'b0);
		run_phase(31'd1, 60, 1'b0);
		run_phase(31'h7FFF_FFFF, 100, 1'b1);
		run_phase('0, 50, 1'b0);
		run_phase(31'($urandom_range(1, 32'h7FFF_FFFF)), 120, 1'b0);
		run_phase(TTL_RESET, 100, 1'b0);

		settle();
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
